### hw/rtl/lpd_pkg.sv
// Shared types and constants for the length-prefixed block deframer.
package lpd_pkg;

  localparam int LENGTH_BITS_DEFAULT = 16;

  localparam logic [7:0] REPLY_OK          = 8'hE0;
  localparam logic [7:0] REPLY_CHECK_ERROR = 8'hE2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_length;
    logic        check_failed;
    logic [7:0]  reply_byte;
    logic        end_of_frame;
  } lpd_result_t;

endpackage

### hw/rtl/lpd_frame_ctrl.sv
// Frame state tracking, running XOR and result formation for each received word.
module lpd_frame_ctrl #(
  parameter int LENGTH_BITS = lpd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          rx_byte,
  output logic                res_valid,
  output lpd_pkg::lpd_result_t res
);

  typedef enum logic [1:0] {
    PH_LEN_LO = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_DATA   = 2'd2,
    PH_CHECK  = 2'd3
  } phase_t;

  localparam logic [LENGTH_BITS-1:0] LEN_ONE  = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
  localparam logic [LENGTH_BITS-1:0] LEN_ZERO = '0;

  phase_t                 phase;
  logic [7:0]             length_low;
  logic [LENGTH_BITS-1:0] declared_length;
  logic [LENGTH_BITS-1:0] bytes_left;
  logic [LENGTH_BITS-1:0] position;
  logic [7:0]             running_xor;

  logic [15:0]            length_word;
  logic [LENGTH_BITS-1:0] length_next;
  logic [LENGTH_BITS-1:0] bytes_left_next;
  logic                   bad;

  assign length_word     = {rx_byte, length_low};
  assign length_next     = length_word[LENGTH_BITS-1:0];
  assign bytes_left_next = bytes_left - LEN_ONE;
  assign bad             = (rx_byte != running_xor);

  always_comb begin
    res_valid        = 1'b0;
    res.item_kind    = lpd_pkg::KIND_PAYLOAD;
    res.payload_byte = 8'h00;
    res.byte_index   = 16'h0000;
    res.frame_length = 16'(declared_length);
    res.check_failed = 1'b0;
    res.reply_byte   = 8'h00;
    res.end_of_frame = 1'b0;
    case (phase)
      PH_DATA: begin
        res_valid        = 1'b1;
        res.payload_byte = rx_byte;
        res.byte_index   = 16'(position);
      end
      PH_CHECK: begin
        res_valid        = 1'b1;
        res.item_kind    = lpd_pkg::KIND_STATUS;
        res.check_failed = bad;
        res.reply_byte   = bad ? lpd_pkg::REPLY_CHECK_ERROR : lpd_pkg::REPLY_OK;
        res.end_of_frame = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LEN_LO;
      length_low      <= 8'h00;
      declared_length <= LEN_ZERO;
      bytes_left      <= LEN_ZERO;
      position        <= LEN_ZERO;
      running_xor     <= 8'h00;
    end else if (fire) begin
      case (phase)
        PH_LEN_LO: begin
          length_low <= rx_byte;
          phase      <= PH_LEN_HI;
        end
        PH_LEN_HI: begin
          declared_length <= length_next;
          bytes_left      <= length_next;
          position        <= LEN_ZERO;
          running_xor     <= 8'h00;
          phase           <= (length_next == LEN_ZERO) ? PH_CHECK : PH_DATA;
        end
        PH_DATA: begin
          running_xor <= running_xor ^ rx_byte;
          position    <= position + LEN_ONE;
          bytes_left  <= bytes_left_next;
          if (bytes_left_next == LEN_ZERO) begin
            phase <= PH_CHECK;
          end
        end
        default: begin
          running_xor <= 8'h00;
          position    <= LEN_ZERO;
          bytes_left  <= LEN_ZERO;
          phase       <= PH_LEN_LO;
        end
      endcase
    end
  end

endmodule

### hw/rtl/lpd_out_buf.sv
// Two-entry output register with skid stage for the result channel.
module lpd_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lpd_pkg::lpd_result_t push_data,
  output logic                 can_accept,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lpd_pkg::lpd_result_t out_data
);

  logic                 main_valid;
  logic                 skid_valid;
  lpd_pkg::lpd_result_t main_data;
  lpd_pkg::lpd_result_t skid_data;
  logic                 pop;

  assign can_accept = !skid_valid;
  assign out_valid  = main_valid;
  assign out_data   = main_data;
  assign pop        = main_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          main_data  <= skid_data;
          skid_valid <= 1'b0;
        end
      end else if (push) begin
        if (!main_valid || pop) begin
          main_data  <= push_data;
          main_valid <= 1'b1;
        end else begin
          skid_data  <= push_data;
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        main_valid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/length_prefixed_block_deframer.sv
// Top level of the length-prefixed block deframer with XOR checksum.
// Each result is registered in the output buffer, passing through the skid stage when the main entry is held.
// Throughput: one word per cycle while the skid stage is empty; the two-entry output buffer sets the stall point.
// Length words produce no result and are taken whenever the skid stage is empty.
// Reset clears the frame state to expect a length low byte and empties the buffer.
module length_prefixed_block_deframer #(
  parameter int LENGTH_BITS = lpd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  rx_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        item_kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] byte_index,
  output logic [15:0] frame_length,
  output logic        check_failed,
  output logic [7:0]  reply_byte,
  output logic        end_of_frame
);

  logic                 fire;
  logic                 res_valid;
  lpd_pkg::lpd_result_t res;
  lpd_pkg::lpd_result_t out_data;

  assign fire = byte_valid && byte_ready;

  lpd_frame_ctrl #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  lpd_out_buf u_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (fire && res_valid),
    .push_data  (res),
    .can_accept (byte_ready),
    .out_valid  (result_valid),
    .out_ready  (result_ready),
    .out_data   (out_data)
  );

  assign item_kind    = out_data.item_kind;
  assign payload_byte = out_data.payload_byte;
  assign byte_index   = out_data.byte_index;
  assign frame_length = out_data.frame_length;
  assign check_failed = out_data.check_failed;
  assign reply_byte   = out_data.reply_byte;
  assign end_of_frame = out_data.end_of_frame;

  a_ready_after_reset: assert property (@(posedge clk) !rst && $past(rst) |-> byte_ready)
    else $error("buffer not empty after reset");

  a_index_in_frame: assert property (@(posedge clk) disable iff (rst)
    result_valid && item_kind == lpd_pkg::KIND_PAYLOAD |-> byte_index < frame_length)
    else $error("payload index beyond declared length");

  a_status_reply: assert property (@(posedge clk) disable iff (rst)
    result_valid && item_kind == lpd_pkg::KIND_STATUS |->
      end_of_frame && (check_failed ? reply_byte == lpd_pkg::REPLY_CHECK_ERROR
                                    : reply_byte == lpd_pkg::REPLY_OK))
    else $error("status reply inconsistent with check result");

endmodule
